// File: src/word_multiply_line_hash_unit_assert.svh
// Assertion macros for the word multiply line hash unit.
// Used by modules that take clk_i and rst_ni; no other dependencies.
`ifndef WORD_MULTIPLY_LINE_HASH_UNIT_ASSERT_SVH
`define WORD_MULTIPLY_LINE_HASH_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define WMLH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wmlh assertion failed");
`define WMLH_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("wmlh forbidden condition seen");
`else
`define WMLH_ASSERT(lbl, prop)
`define WMLH_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: src/wmlh_pkg.sv
// Package for the word multiply line hash unit: constants, codes and types.
// No dependencies.
package wmlh_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned HALF_W  = 32;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned LEN_W   = 48;
  localparam int unsigned BYTES   = 8;

  localparam logic [WORD_W-1:0] SEED_BASE = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WORD_W-1:0] MIX_MULT  = 64'hFF51_AFD7_ED55_8CCD;
  localparam logic [WORD_W-1:0] FNV_PRIME = 64'd1099511628211;
  localparam int unsigned       FIN_SHIFT = 33;

  localparam int unsigned STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_LO_LO = 2'd0;
  localparam logic [STEP_W-1:0] STEP_LO_HI = 2'd1;
  localparam logic [STEP_W-1:0] STEP_HI_LO = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIX,
    ST_FIN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    OP_SEED,
    OP_MIX,
    OP_FIN
  } mul_op_e;

  typedef struct packed {
    logic first;
    logic last;
    logic mix;
  } item_flags_t;

  typedef struct packed {
    item_flags_t in_flags;
    item_flags_t held_flags;
  } dp_status_t;

  typedef struct packed {
    logic              load_item;
    logic              mul_en;
    mul_op_e           op;
    logic [STEP_W-1:0] step;
    logic              out_load;
  } dp_cmd_t;

  function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] count);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < BYTES; i++) begin
      m[8*i +: 8] = (COUNT_W'(i) < count) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: src/wmlh_in_if.sv
// Input channel of the hash unit: one 64-bit word of a string per item.
// Depends on wmlh_pkg.
interface wmlh_in_if
  import wmlh_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   data_word;
  logic [COUNT_W-1:0]  byte_count;
  logic                first_word;
  logic                last_word;
  logic [LEN_W-1:0]    string_length;

  modport source (output valid, data_word, byte_count, first_word, last_word,
                  string_length, input ready);
  modport sink   (input valid, data_word, byte_count, first_word, last_word,
                  string_length, output ready);
endinterface

// File: src/wmlh_out_if.sv
// Output channel of the hash unit: one finished 64-bit hash per item.
// Depends on wmlh_pkg.
interface wmlh_out_if
  import wmlh_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// File: src/wmlh_datapath.sv
// Datapath: item registers, running hash, shared 32x32 multiplier, output register.
// Depends on wmlh_pkg; driven by wmlh_ctrl through dp_cmd_t.
module wmlh_datapath
  import wmlh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [WORD_W-1:0]  data_word_i,
  input  logic [COUNT_W-1:0] byte_count_i,
  input  logic               first_word_i,
  input  logic               last_word_i,
  input  logic [LEN_W-1:0]   string_length_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  output logic [WORD_W-1:0]  hash_value_o
);

  logic [WORD_W-1:0]  word_q;
  logic [COUNT_W-1:0] count_q;
  logic [LEN_W-1:0]   len_q;
  item_flags_t        flags_q;
  logic [WORD_W-1:0]  hash_q, hash_d;
  logic [WORD_W-1:0]  acc_q, acc_d;
  logic [WORD_W-1:0]  out_q;

  logic [WORD_W-1:0]  op_a, op_b;
  logic [HALF_W-1:0]  mul_x, mul_y;
  logic [WORD_W-1:0]  prod;

  always_comb begin
    status_o.in_flags.first = first_word_i;
    status_o.in_flags.last  = last_word_i;
    status_o.in_flags.mix   = (byte_count_i != '0);
    status_o.held_flags     = flags_q;
  end

  always_comb begin
    case (cmd_i.op)
      OP_SEED: begin
        op_a = {{(WORD_W-LEN_W){1'b0}}, len_q};
        op_b = MIX_MULT;
      end
      OP_MIX: begin
        op_a = hash_q ^ (word_q & byte_mask(count_q));
        op_b = FNV_PRIME;
      end
      default: begin
        op_a = hash_q ^ (hash_q >> FIN_SHIFT);
        op_b = MIX_MULT;
      end
    endcase
  end

  // low 64 bits of a*b: lo*lo, then the two cross terms shifted up
  assign mul_x = (cmd_i.step == STEP_HI_LO) ? op_a[WORD_W-1:HALF_W] : op_a[HALF_W-1:0];
  assign mul_y = (cmd_i.step == STEP_LO_HI) ? op_b[WORD_W-1:HALF_W] : op_b[HALF_W-1:0];
  assign prod  = WORD_W'(mul_x) * WORD_W'(mul_y);

  always_comb begin
    acc_d  = acc_q;
    hash_d = hash_q;
    if (cmd_i.mul_en) begin
      if (cmd_i.step == STEP_LO_LO) begin
        acc_d = prod;
      end else begin
        acc_d = acc_q + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      end
      if (cmd_i.step == STEP_HI_LO) begin
        case (cmd_i.op)
          OP_SEED: hash_d = SEED_BASE ^ acc_d;
          OP_MIX:  hash_d = acc_d;
          default: hash_d = hash_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.load_item) begin
      word_q  <= data_word_i;
      count_q <= byte_count_i;
      len_q   <= string_length_i;
      flags_q <= status_o.in_flags;
    end
    if (cmd_i.out_load) begin
      out_q <= acc_q ^ (acc_q >> FIN_SHIFT);
    end
  end

  assign hash_value_o = out_q;

endmodule

// File: src/wmlh_ctrl.sv
// Controller: sequences seed, mix and finalise multiplies, owns the handshakes.
// Depends on wmlh_pkg and word_multiply_line_hash_unit_assert.svh.
`include "word_multiply_line_hash_unit_assert.svh"
module wmlh_ctrl
  import wmlh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              step_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign step_last = (step_q == STEP_HI_LO);

  always_comb begin
    state_d = state_q;
    step_d  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_flags.first) begin
            state_d = ST_SEED;
          end else if (status_i.in_flags.mix) begin
            state_d = ST_MIX;
          end else if (status_i.in_flags.last) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SEED: begin
        step_d = step_q + 1'b1;
        if (step_last) begin
          step_d = '0;
          if (status_i.held_flags.mix) begin
            state_d = ST_MIX;
          end else if (status_i.held_flags.last) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MIX: begin
        step_d = step_q + 1'b1;
        if (step_last) begin
          step_d  = '0;
          state_d = status_i.held_flags.last ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        step_d = step_q + 1'b1;
        if (step_last) begin
          step_d  = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.load_item = 1'b0;
    cmd_o.mul_en    = 1'b0;
    cmd_o.op        = OP_FIN;
    cmd_o.step      = step_q;
    cmd_o.out_load  = 1'b0;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_SEED: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_SEED;
      end
      ST_MIX: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_MIX;
      end
      ST_FIN: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_FIN;
      end
      ST_EMIT: begin
        cmd_o.out_load = out_free;
      end
      default: begin
        cmd_o.mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `WMLH_ASSERT_NEVER(a_step_range, step_q == 2'd3)
  `WMLH_ASSERT(a_fin_to_emit, (state_q == ST_FIN && step_last) |=> state_q == ST_EMIT)
  `WMLH_ASSERT(a_result_from_emit, $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
  `WMLH_ASSERT(a_first_seeds,
    (state_q == ST_IDLE && in_valid_i && status_i.in_flags.first)
      |=> (state_q == ST_SEED && step_q == STEP_LO_LO))

endmodule

// File: src/word_multiply_line_hash_unit.sv
// Top level of the word multiply line hash unit: controller plus datapath.
// Depends on wmlh_pkg, wmlh_in_if, wmlh_out_if, wmlh_ctrl and wmlh_datapath.
//
//  channel | direction | content
//  in_i    | sink      | data_word, byte_count, first_word, last_word, string_length
//  out_o   | source    | hash_value of a finished string
//
// An item is taken in the idle state, then each 64-bit multiply runs on the single
// 32x32 multiplier in the steps lo*lo, lo*hi and hi*lo: seed (first item), mix
// (non-zero byte count), finalise (last item); the output register is loaded
// last. Reset clears the running hash to zero. A held result stalls the finalise
// hand-off, and no new item is taken while it waits.
module word_multiply_line_hash_unit
  import wmlh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  wmlh_in_if.sink    in_i,
  wmlh_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  wmlh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wmlh_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_word_i     (in_i.data_word),
    .byte_count_i    (in_i.byte_count),
    .first_word_i    (in_i.first_word),
    .last_word_i     (in_i.last_word),
    .string_length_i (in_i.string_length),
    .cmd_i           (cmd),
    .status_o        (status),
    .hash_value_o    (out_o.hash_value)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for word_multiply_line_hash_unit: line words in, finished hashes out.
// Predicts every hash from the accepted words and compares each result with the oldest prediction.
// Depends on wmlh_pkg, wmlh_in_if, wmlh_out_if and the unit itself.
`timescale 1ns / 1ps

module tb_top;
  import wmlh_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 420;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic               first;
    logic               last;
    logic [LEN_W-1:0]   len;
  } line_word_t;

  typedef enum logic [2:0] {
    PH_BURST,
    PH_HOLD,
    PH_SRC_IDLE,
    PH_SINK_STALL,
    PH_BOTH
  } pace_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  pace_e       pace = PH_BURST;

  logic        drv_valid = 1'b0;
  line_word_t  drv_word = '0;
  logic        sink_ready = 1'b0;

  line_word_t        line_words[$];
  logic [WORD_W-1:0] expected_hashes[$];
  logic [WORD_W-1:0] line_hash = '0;
  int unsigned       mismatches = 0;
  int unsigned       hold_cycles = 0;
  int unsigned       quiet_cycles = 0;

  wmlh_in_if  in_ch ();
  wmlh_out_if out_ch ();

  assign in_ch.valid         = drv_valid;
  assign in_ch.data_word     = drv_word.word;
  assign in_ch.byte_count    = drv_word.count;
  assign in_ch.first_word    = drv_word.first;
  assign in_ch.last_word     = drv_word.last;
  assign in_ch.string_length = drv_word.len;
  assign out_ch.ready        = sink_ready;

  word_multiply_line_hash_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Seed, mix, then finalise, in that order within one item.
  function automatic logic hash_line_word(input line_word_t w, output logic [WORD_W-1:0] hash);
    logic [WORD_W-1:0] keep;
    logic [WORD_W-1:0] h;
    keep = (w.count >= COUNT_W'(BYTES)) ? '1 : ((64'd1 << (8 * w.count)) - 64'd1);
    if (w.first) line_hash = SEED_BASE ^ ({{(WORD_W-LEN_W){1'b0}}, w.len} * MIX_MULT);
    if (w.count != '0) line_hash = (line_hash ^ (w.word & keep)) * FNV_PRIME;
    h = line_hash;
    h = h ^ (h >> FIN_SHIFT);
    h = h * MIX_MULT;
    hash = h ^ (h >> FIN_SHIFT);
    return w.last;
  endfunction

  function automatic int unsigned src_idle_pct(input pace_e p);
    case (p)
      PH_SRC_IDLE: return 52;
      PH_BOTH:     return 34;
      default:     return 0;
    endcase
  endfunction

  function automatic int unsigned sink_stall_pct(input pace_e p);
    case (p)
      PH_SINK_STALL: return 52;
      PH_BOTH:       return 34;
      default:       return 0;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rnd_word();
    return {$urandom, $urandom};
  endfunction

  // Sender: holds an offered item until taken, then picks the next one or idles.
  always @(posedge clk) begin
    logic [WORD_W-1:0] h;
    if (rst_n) begin
      if (drv_valid && in_ch.ready) begin
        if (hash_line_word(drv_word, h)) expected_hashes.insert(expected_hashes.size(), h);
      end
      if (drv_valid && !in_ch.ready) begin
        drv_valid <= 1'b1;
      end else if (line_words.size() != 0 && $urandom_range(99) >= src_idle_pct(pace)) begin
        drv_word  <= line_words.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each hash, stalls at random or for one long hold-off.
  always @(posedge clk) begin
    logic [WORD_W-1:0] exp_hash;
    if (rst_n) begin
      if (out_ch.valid && sink_ready) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value: expected none, actual %h", out_ch.hash_value);
          mismatches++;
        end else begin
          exp_hash = expected_hashes.pop_front();
          if (exp_hash !== out_ch.hash_value) begin
            $error("hash_value: expected %h, actual %h", exp_hash, out_ch.hash_value);
            mismatches++;
          end
        end
      end
      if (pace == PH_HOLD && hold_cycles < HOLD_CYCLES) begin
        hold_cycles <= hold_cycles + 1;
        sink_ready  <= 1'b0;
      end else begin
        sink_ready <= ($urandom_range(99) >= sink_stall_pct(pace));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic add_word(input logic [WORD_W-1:0] word, input int unsigned count,
                          input logic first, input logic last, input logic [LEN_W-1:0] len);
    line_word_t w;
    w.word  = word;
    w.count = COUNT_W'(count);
    w.first = first;
    w.last  = last;
    w.len   = len;
    line_words.insert(line_words.size(), w);
  endtask

  // A well-formed line: full words then a tail, length field mostly true.
  task automatic add_line(output int unsigned n_words);
    int unsigned nbytes;
    int unsigned i;
    logic [LEN_W-1:0] len;
    nbytes = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(48);
    len = ($urandom_range(15) == 0) ? LEN_W'({$urandom, $urandom}) : LEN_W'(nbytes);
    n_words = (nbytes == 0) ? 1 : (nbytes + 7) / 8;
    for (i = 0; i < n_words; i++) begin
      add_word(rnd_word(), (i == n_words - 1) ? nbytes - 8 * i : 8,
               i == 0, i == n_words - 1, len);
    end
  endtask

  task automatic add_noise();
    add_word(rnd_word(), $urandom_range(15), 1'($urandom), 1'($urandom),
             LEN_W'({$urandom, $urandom}));
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (line_words.size() != 0 || drv_valid || expected_hashes.size() != 0);
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        add_noise();
        sent++;
      end else begin
        add_line(n);
        sent += n;
      end
      if ($urandom_range(59) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    int unsigned c;
    int unsigned n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // mixing straight from the reset value, no seed
    add_word(rnd_word(), 8, 1'b0, 1'b1, '0);
    // empty line
    add_word(rnd_word(), 0, 1'b1, 1'b1, '0);
    add_word('1, 8, 1'b1, 1'b1, '1);
    add_word('0, 8, 1'b1, 1'b1, LEN_W'(8));
    for (c = 1; c < 8; c++) add_word('1, c, 1'b1, 1'b1, LEN_W'(c));
    // counts above eight take the whole word
    add_word(rnd_word(), 9, 1'b1, 1'b1, LEN_W'(9));
    add_word(rnd_word(), 15, 1'b1, 1'b1, LEN_W'(15));
    // seed only, a do-nothing item, then a tail
    add_word(rnd_word(), 0, 1'b1, 1'b0, LEN_W'(3));
    add_word(rnd_word(), 0, 1'b0, 1'b0, '0);
    add_word(rnd_word(), 3, 1'b0, 1'b1, '0);
    // keeps mixing after an emission
    add_word(rnd_word(), 8, 1'b0, 1'b1, '0);
    // reseed in the middle of a line
    add_word(rnd_word(), 8, 1'b1, 1'b0, LEN_W'(13));
    add_word(rnd_word(), 5, 1'b1, 1'b1, LEN_W'(5));
    wait_drained();

    pace = PH_HOLD;
    for (c = 0; c < 12; c++) add_line(n);
    wait_drained();

    pace = PH_BURST;
    run_random(PHASE_ITEMS);
    pace = PH_SRC_IDLE;
    run_random(PHASE_ITEMS);
    pace = PH_SINK_STALL;
    run_random(PHASE_ITEMS);
    pace = PH_BOTH;
    run_random(PHASE_ITEMS);

    repeat (50) @(posedge clk);
    if (expected_hashes.size() != 0) begin
      $error("hash_value: %0d expected, none arrived", expected_hashes.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
